// ----- hdl/sssp_pkg.sv -----
// shared types and constants for the shortest path block
package sssp_pkg;

    localparam int VERT_W   = 10;
    localparam int WT_IN_W  = 16;
    localparam int DIST_W   = 26;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [VERT_W-1:0]  edge_source;
        logic [VERT_W-1:0]  edge_target;
        logic [WT_IN_W-1:0] edge_weight;
        logic [VERT_W-1:0]  start_vertex;
        logic [VERT_W-1:0]  query_vertex;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [DIST_W-1:0]  path_length;
        logic [VERT_W-1:0]  previous_vertex;
        logic               reached;
    } out_item_t;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // capture the input item
        CMD_HCLR,       // clear one list head (sweep)
        CMD_HREAD,      // read the list head of the edge source
        CMD_ADD,        // write one edge
        CMD_INIT,       // clear one vertex run state (sweep)
        CMD_SEED,       // mark start vertex
        CMD_SCAN,       // issue read of one vertex for the minimum search
        CMD_SETTLE,     // settle chosen vertex, read its list head
        CMD_EREAD,      // issue edge read
        CMD_RELAX,      // form candidate distance, step to the next edge
        CMD_TREAD,      // read target state
        CMD_UPD,        // write improved target
        CMD_QREAD,      // issue query read
        CMD_RESULT      // load output register
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic sweep_first;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] op;
        logic       sweep_last;  // sweep index at final entry
        logic       scan_last;
        logic       found;       // minimum search found a vertex
        logic       edge_ok;     // current edge pointer is a live edge
        logic       start_ok;
        logic       add_ok;
    } dp_stat_t;

endpackage

// ----- hdl/sssp_datapath.sv -----
// edge store, vertex state memories and the arithmetic of a run
module sssp_datapath
    import sssp_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096,
    parameter int WEIGHT_BITS  = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  dp_ctrl_t  ctrl,
    output dp_stat_t  stat,
    output out_item_t result
);

    localparam int VI_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EI_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int WB   = (WEIGHT_BITS < WT_IN_W) ? WEIGHT_BITS : WT_IN_W;
    localparam int SW_W = (VI_W > EI_W) ? VI_W : EI_W;
    localparam int HD_W = EC_W + 1;

    // memories
    logic [VI_W-1:0]       e_tgt_mem [MAX_EDGES];
    logic [WB-1:0]         e_wt_mem  [MAX_EDGES];
    logic [HD_W-1:0]       e_lnk_mem [MAX_EDGES];
    logic [HD_W-1:0]       head_mem  [MAX_VERTICES];
    logic [DIST_W-1:0]     dist_mem  [MAX_VERTICES];
    logic [VERT_W-1:0]     pred_mem  [MAX_VERTICES];
    logic                  settled_mem [MAX_VERTICES];
    logic                  reach_mem   [MAX_VERTICES];

    in_item_t          item_reg;
    logic [EC_W-1:0]   count_reg;
    logic [VI_W:0]     sweep_reg;
    logic [VI_W-1:0]   pick_reg;
    logic [DIST_W-1:0] pick_dist_reg;
    logic              found_reg;
    logic [HD_W-1:0]   eptr_reg;
    logic [VI_W-1:0]   tgt_reg;
    logic [DIST_W-1:0] cand_reg;
    logic              rd_valid_reg;
    logic [VI_W-1:0]   rd_idx_reg;
    logic              add_fail_reg;
    logic              ran_reg;
    // registered memory reads
    logic [HD_W-1:0]   head_q;
    logic [DIST_W-1:0] dist_q;
    logic [VERT_W-1:0] pred_q;
    logic              settled_q;
    logic              reach_q;
    logic [VI_W-1:0]   etgt_q;
    logic [WB-1:0]     ewt_q;
    logic [HD_W-1:0]   elnk_q;
    out_item_t         result_reg;
    out_item_t         result_next;

    logic [VI_W-1:0] vaddr;
    logic [EI_W-1:0] eaddr;
    logic [DIST_W:0] sum;
    logic            src_ok, dst_ok, q_ok, start_ok;
    logic [HD_W-1:0] empty_mark;

    assign empty_mark = {HD_W{1'b1}};
    assign src_ok   = (17'(item_reg.edge_source) < 17'(MAX_VERTICES));
    assign dst_ok   = (17'(item_reg.edge_target) < 17'(MAX_VERTICES));
    assign q_ok     = (17'(item_reg.query_vertex) < 17'(MAX_VERTICES));
    assign start_ok = (17'(item_reg.start_vertex) < 17'(MAX_VERTICES));

    // vertex memory address by command
    always_comb
    begin
        unique case (ctrl.cmd)
            CMD_HCLR, CMD_INIT, CMD_SCAN: vaddr = sweep_reg[VI_W-1:0];
            CMD_HREAD, CMD_ADD: vaddr = VI_W'(item_reg.edge_source);
            CMD_SEED:   vaddr = VI_W'(item_reg.start_vertex);
            CMD_SETTLE, CMD_EREAD: vaddr = pick_reg;
            CMD_TREAD, CMD_UPD: vaddr = tgt_reg;
            CMD_QREAD:  vaddr = VI_W'(item_reg.query_vertex);
            default:    vaddr = pick_reg;
        endcase
    end

    assign eaddr = EI_W'(eptr_reg);
    assign sum   = {1'b0, dist_q} + (DIST_W+1)'(ewt_q);

    // vertex memories
    always_ff @(posedge clk)
    begin
        head_q    <= head_mem[vaddr];
        dist_q    <= dist_mem[vaddr];
        pred_q    <= pred_mem[vaddr];
        settled_q <= settled_mem[vaddr];
        reach_q   <= reach_mem[vaddr];
        if (ctrl.cmd == CMD_HCLR)
            head_mem[vaddr] <= empty_mark;
        if (ctrl.cmd == CMD_ADD && src_ok && dst_ok && count_reg < EC_W'(MAX_EDGES))
            head_mem[vaddr] <= HD_W'(count_reg);
        if (ctrl.cmd == CMD_INIT)
        begin
            settled_mem[vaddr] <= 1'b0;
            reach_mem[vaddr]   <= 1'b0;
            dist_mem[vaddr]    <= '0;
        end
        if (ctrl.cmd == CMD_SEED && start_ok)
        begin
            reach_mem[vaddr] <= 1'b1;
            pred_mem[vaddr]  <= VERT_W'(item_reg.start_vertex);
        end
        if (ctrl.cmd == CMD_SETTLE)
            settled_mem[vaddr] <= 1'b1;
        if (ctrl.cmd == CMD_UPD && (!reach_q || cand_reg < dist_q))
        begin
            reach_mem[vaddr] <= 1'b1;
            dist_mem[vaddr]  <= cand_reg;
            pred_mem[vaddr]  <= VERT_W'(pick_reg);
        end
    end

    // edge memories
    always_ff @(posedge clk)
    begin
        etgt_q <= e_tgt_mem[eaddr];
        ewt_q  <= e_wt_mem[eaddr];
        elnk_q <= e_lnk_mem[eaddr];
        if (ctrl.cmd == CMD_ADD && src_ok && dst_ok && count_reg < EC_W'(MAX_EDGES))
        begin
            e_tgt_mem[EI_W'(count_reg)] <= VI_W'(item_reg.edge_target);
            e_wt_mem[EI_W'(count_reg)]  <= item_reg.edge_weight[WB-1:0];
            e_lnk_mem[EI_W'(count_reg)] <= head_q;
        end
    end

    // result of the current item; reads before any run report unreached
    always_comb
    begin
        result_next = '0;
        if (item_reg.operation == OP_ADD)
            result_next.status = add_fail_reg;
        if (item_reg.operation == OP_READ && q_ok && ran_reg && reach_q)
        begin
            result_next.reached         = 1'b1;
            result_next.path_length     = dist_q;
            result_next.previous_vertex = pred_q;
        end
    end

    // control registers of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sweep_reg    <= '0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            add_fail_reg <= 1'b0;
            ran_reg      <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= (ctrl.cmd == CMD_SCAN);
            rd_idx_reg   <= sweep_reg[VI_W-1:0];
            if (ctrl.sweep_first)
            begin
                sweep_reg <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.cmd == CMD_HCLR || ctrl.cmd == CMD_INIT || ctrl.cmd == CMD_SCAN)
                    sweep_reg <= sweep_reg + 1'b1;
                // minimum search compares the previous cycle's read
                if (rd_valid_reg && reach_q && !settled_q &&
                    (!found_reg || dist_q < pick_dist_reg))
                begin
                    found_reg     <= 1'b1;
                    pick_reg      <= rd_idx_reg;
                    pick_dist_reg <= dist_q;
                end
            end
            unique case (ctrl.cmd)
                CMD_LATCH:  item_reg <= in_item;
                CMD_HCLR:   count_reg <= '0;
                CMD_ADD:
                begin
                    // keep the drop status, the count moves on before the result
                    add_fail_reg <= !(src_ok && dst_ok && count_reg < EC_W'(MAX_EDGES));
                    if (src_ok && dst_ok && count_reg < EC_W'(MAX_EDGES))
                        count_reg <= count_reg + 1'b1;
                end
                CMD_INIT:   ran_reg <= 1'b1;
                CMD_EREAD:
                    if (ctrl.sweep_first)
                        eptr_reg <= head_q;
                CMD_RELAX:
                begin
                    tgt_reg  <= etgt_q;
                    cand_reg <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
                    eptr_reg <= elnk_q;
                end
                CMD_RESULT: result_reg <= result_next;
                default: ;
            endcase
        end
    end

    assign stat.op         = item_reg.operation;
    assign stat.sweep_last = (sweep_reg[VI_W-1:0] == VI_W'(MAX_VERTICES - 1));
    assign stat.scan_last  = (sweep_reg == (VI_W+1)'(MAX_VERTICES));
    assign stat.found      = found_reg;
    assign stat.edge_ok    = (eptr_reg < HD_W'(count_reg)) &&
                             (eptr_reg < HD_W'(MAX_EDGES));
    assign stat.start_ok   = start_ok;
    assign stat.add_ok     = src_ok && dst_ok;
    assign result          = result_reg;

endmodule

// ----- hdl/sssp_ctrl.sv -----
// controller sequencing clears, edge loads, runs and reads
module sssp_ctrl
    import sssp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_INIT_CLR, S_IDLE, S_DECODE, S_HCLR, S_ADD_RD, S_ADD_WR,
        S_VINIT, S_SEED, S_SCAN, S_SCAN_END, S_SETTLE, S_EHEAD,
        S_EREAD, S_RELAX, S_TREAD, S_UPD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   first_reg;
    logic   first_next;
    logic   pend_reg;
    logic   out_free;

    // output register is free when empty or being taken this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        ctrl.sweep_first = first_reg;
        unique case (state_reg)
            S_IDLE:     ctrl.cmd = (in_valid && in_ready) ? CMD_LATCH : CMD_NONE;
            S_INIT_CLR, S_HCLR: ctrl.cmd = CMD_HCLR;
            S_ADD_RD:   ctrl.cmd = CMD_HREAD;
            S_ADD_WR:   ctrl.cmd = CMD_ADD;
            S_VINIT:    ctrl.cmd = CMD_INIT;
            S_SEED:     ctrl.cmd = CMD_SEED;
            S_SCAN:     ctrl.cmd = (first_reg || stat.scan_last) ? CMD_NONE : CMD_SCAN;
            S_SETTLE:   ctrl.cmd = CMD_SETTLE;
            S_EHEAD:
            begin
                ctrl.cmd         = CMD_EREAD;
                ctrl.sweep_first = 1'b1;
            end
            S_EREAD:    ctrl.cmd = CMD_EREAD;
            S_RELAX:    ctrl.cmd = CMD_RELAX;
            S_TREAD:    ctrl.cmd = CMD_TREAD;
            S_UPD:      ctrl.cmd = CMD_UPD;
            // query read is repeated while the result waits for the output register
            S_DECODE:   ctrl.cmd = (pend_reg && out_free) ? CMD_RESULT : CMD_QREAD;
            default:    ctrl.cmd = CMD_NONE;
        endcase
    end

    // first cycle of a sweep or scan
    always_comb
    begin
        first_next = 1'b0;
        if (state_reg == S_DECODE && !pend_reg &&
            (op_t'(stat.op) == OP_CLEAR || op_t'(stat.op) == OP_RUN))
            first_next = 1'b1;
        if (state_reg == S_SEED && stat.start_ok)
            first_next = 1'b1;
        if (state_reg == S_EREAD && !stat.edge_ok)
            first_next = 1'b1;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_CLR;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b1;
            pend_reg      <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            if (state_reg == S_DECODE && pend_reg && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT_CLR:
                    if (!first_reg && stat.sweep_last)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        state_reg <= S_DECODE;
                        pend_reg  <= 1'b0;
                    end
                S_DECODE:
                    if (pend_reg)
                    begin
                        if (out_free)
                            state_reg <= S_IDLE;
                    end
                    else
                    begin
                        unique case (op_t'(stat.op))
                            OP_CLEAR: state_reg <= S_HCLR;
                            OP_ADD:   state_reg <= S_ADD_RD;
                            OP_RUN:   state_reg <= S_VINIT;
                            default:  pend_reg <= 1'b1;
                        endcase
                    end
                S_HCLR:
                    if (!first_reg && stat.sweep_last)
                    begin
                        state_reg <= S_DECODE;
                        pend_reg  <= 1'b1;
                    end
                S_ADD_RD:
                begin
                    state_reg <= S_ADD_WR;
                end
                S_ADD_WR:
                begin
                    state_reg <= S_DECODE;
                    pend_reg  <= 1'b1;
                end
                S_VINIT:
                    if (!first_reg && stat.sweep_last)
                        state_reg <= S_SEED;
                S_SEED:
                    if (stat.start_ok)
                        state_reg <= S_SCAN;
                    else
                    begin
                        state_reg <= S_DECODE;
                        pend_reg  <= 1'b1;
                    end
                S_SCAN:
                    if (!first_reg && stat.scan_last)
                        state_reg <= S_SCAN_END;
                S_SCAN_END:
                    if (stat.found)
                        state_reg <= S_SETTLE;
                    else
                    begin
                        state_reg <= S_DECODE;
                        pend_reg  <= 1'b1;
                    end
                S_SETTLE: state_reg <= S_EHEAD;
                S_EHEAD:  state_reg <= S_EREAD;
                S_EREAD:
                    if (stat.edge_ok)
                        state_reg <= S_RELAX;
                    else
                        state_reg <= S_SCAN;
                S_RELAX:  state_reg <= S_TREAD;
                S_TREAD:  state_reg <= S_UPD;
                S_UPD:    state_reg <= S_EREAD;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/single_source_shortest_path.sv -----
// Dijkstra shortest paths over a stored graph: top level
// clear sweeps the list heads; add edge reads the source list head and writes the edge
// run: init sweep and seed, then per settled vertex a scan and settle plus, per outgoing
// edge, edge read, relax, target read and update; a closing scan ends the run
// one item at a time; while the output register is full a new result waits, holding off input
// after reset a sweep clears list heads before ready
module single_source_shortest_path
    import sssp_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096,
    parameter int WEIGHT_BITS  = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    sssp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
    );

    sssp_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .ctrl(ctrl),
        .stat(stat), .result(out_data)
    );

endmodule
